// ----- src/cms_pkg.sv -----
// ----------------------------------------------------------------------------
// cms_pkg: shared types, constants and helpers for the circular motion step
// Holds fixed widths, register indexes, the CORDIC arctangent table, the
// sequencer state types and the 32-bit saturation helper.
// ----------------------------------------------------------------------------
`default_nettype none

package cms_pkg;

    // Default CORDIC stage count (8 to 32)
    localparam int CMS_CORDIC_STAGES = 16;

    // Fixed datapath widths
    localparam int DATA_W    = 32;
    localparam int DT_W      = 16;
    localparam int RADIUS_W  = 31;
    localparam int CORDIC_W  = 34;
    localparam int MUL_W     = 34;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int OFF_W     = 34;
    localparam int SAT_W     = 40;
    localparam int CFG_IDX_W = 3;
    localparam int ATAN_W    = 30;
    localparam int ATAN_N    = 32;
    localparam int ATAN_IDX_W = 5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATH_RADIUS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OMEGA_START = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ANG_ACCEL   = 3'd4;

    // Reset value of the path radius: 1.0 in Q16.16
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 31'd65536;

    // CORDIC start magnitude (gain limit in Q2.30) and 2*pi in Q3.29
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic [DATA_W-1:0] TWO_PI_Q29 = 32'd3373259426;

    // Quarter turn limits in binary angle units
    localparam logic signed [DATA_W-1:0] QTR_POS = 32'sh4000_0000;
    localparam logic signed [DATA_W-1:0] QTR_NEG = 32'shC000_0000;
    localparam logic [DATA_W-1:0] HALF_TURN = 32'h8000_0000;

    // atan(2^-i) in binary angle units, rounded
    localparam logic [ATAN_W-1:0] ATAN_TAB [ATAN_N] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
        30'd42667331,  30'd21354465,  30'd10679838,  30'd5340245,
        30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
        30'd166886,    30'd83443,     30'd41722,     30'd20861,
        30'd10430,     30'd5215,      30'd2608,      30'd1304,
        30'd652,       30'd326,       30'd163,       30'd81,
        30'd41,        30'd20,        30'd10,        30'd5,
        30'd3,         30'd1,         30'd1,         30'd0
    };

    // CORDIC unit states
    typedef enum logic [1:0] {
        CS_IDLE,
        CS_ROT,
        CS_FIN
    } cms_cordic_state_t;

    // Top level sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DTSQ,
        ST_D1,
        ST_D2,
        ST_DR,
        ST_RATE,
        ST_CSTART,
        ST_CWAIT,
        ST_OX,
        ST_OY,
        ST_PX,
        ST_PY,
        ST_VY,
        ST_VX,
        ST_DONE
    } cms_state_t;

    // Request to the CORDIC unit
    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] angle;
    } cms_cordic_req_t;

    // Status and results from the CORDIC unit
    typedef struct packed {
        logic                       done;
        logic signed [CORDIC_W-1:0] cos_v;
        logic signed [CORDIC_W-1:0] sin_v;
    } cms_cordic_res_t;

    // Clamp a wide signed value to 32-bit signed
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > 40'sh00_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < 40'shFF_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- src/cms_mul.sv -----
// ----------------------------------------------------------------------------
// cms_mul: shared signed multiplier
// One 34x34 signed multiply per cycle, product registered when enabled.
// ----------------------------------------------------------------------------
`default_nettype none

module cms_mul import cms_pkg::*; (
    input  logic                     aclk,
    input  logic                     en,
    input  logic signed [MUL_W-1:0]  op_a,
    input  logic signed [MUL_W-1:0]  op_b,
    output logic signed [PROD_W-1:0] prod
);

    logic signed [PROD_W-1:0] prod_reg;

    // Product register, holds while not enabled
    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= op_a * op_b;
        end
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// ----- src/cms_cordic.sv -----
// ----------------------------------------------------------------------------
// cms_cordic: iterative rotation-mode CORDIC
// One micro-rotation per cycle in Q2.30, with a half-turn pre-rotation for
// angles beyond a quarter turn. Results of a pre-rotated angle are negated in the final state.
// ----------------------------------------------------------------------------
`default_nettype none

module cms_cordic import cms_pkg::*; #(
    parameter int CORDIC_STAGES = CMS_CORDIC_STAGES
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  cms_cordic_req_t req,
    output cms_cordic_res_t res
);

    // No more stages than arctangent table entries
    localparam int STAGES_RUN = (CORDIC_STAGES > ATAN_N) ? ATAN_N : CORDIC_STAGES;
    localparam int ITER_W = $clog2(STAGES_RUN);
    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(STAGES_RUN - 1);

    cms_cordic_state_t state_reg, state_next;

    logic [ITER_W-1:0]          iter_reg;
    logic signed [CORDIC_W-1:0] x_reg, y_reg, z_reg;
    logic                       flip_reg;

    logic signed [DATA_W-1:0]   ang_in;
    logic signed [DATA_W-1:0]   ang_sel;
    logic                       flip_init;
    logic signed [CORDIC_W-1:0] dx, dy, dz;

    // Quadrant fold: outside a quarter turn, rotate by half a turn
    assign ang_in    = req.angle;
    assign flip_init = (ang_in > QTR_POS) || (ang_in < QTR_NEG);
    assign ang_sel   = flip_init ? (req.angle ^ HALF_TURN) : req.angle;

    // Shifted terms for the current stage
    assign dx = y_reg >>> iter_reg;
    assign dy = x_reg >>> iter_reg;
    assign dz = {{(CORDIC_W - ATAN_W){1'b0}}, ATAN_TAB[ATAN_IDX_W'(iter_reg)]};

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CS_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            CS_IDLE: begin
                if (req.start) begin
                    state_next = CS_ROT;
                end
            end
            CS_ROT: begin
                if (iter_reg == ITER_LAST) begin
                    state_next = CS_FIN;
                end
            end
            CS_FIN:  state_next = CS_IDLE;
            default: state_next = CS_IDLE;
        endcase
    end

    // Rotation datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            CS_IDLE: begin
                if (req.start) begin
                    x_reg    <= CORDIC_GAIN;
                    y_reg    <= '0;
                    z_reg    <= CORDIC_W'(ang_sel);
                    flip_reg <= flip_init;
                    iter_reg <= '0;
                end
            end
            CS_ROT: begin
                if (z_reg >= 0) begin
                    x_reg <= x_reg - dx;
                    y_reg <= y_reg + dy;
                    z_reg <= z_reg - dz;
                end else begin
                    x_reg <= x_reg + dx;
                    y_reg <= y_reg - dy;
                    z_reg <= z_reg + dz;
                end
                iter_reg <= iter_reg + 1'b1;
            end
            CS_FIN: begin
                if (flip_reg) begin
                    x_reg <= -x_reg;
                    y_reg <= -y_reg;
                end
            end
            default: ;
        endcase
    end

    // Done shows during the final cycle; results settle at its end
    assign res.done  = (state_reg == CS_FIN);
    assign res.cos_v = x_reg;
    assign res.sin_v = y_reg;

endmodule

`default_nettype wire

// ----- src/circular_motion_step_unit.sv -----
// ----------------------------------------------------------------------------
// circular_motion_step_unit: point on a circle under constant angular accel
// Usage:
//   Input beat (s_valid/s_ready): s_mode=1 restarts at angle 0 with rate
//   omega_start; s_mode=0 advances by s_dt seconds (Q0.16). Each input beat
//   gives exactly one result beat (m_valid/m_ready) with position, velocity,
//   angle and rate.
//   Registers are written through cfg_wr_en/cfg_index/cfg_wdata, one per
//   cycle. The user must write them only while the unit is idle; the block
//   itself does not enforce this. Unknown indexes are ignored.
//   A step beat runs the CORDIC loop (one stage a cycle) and ten products
//   through the one multiplier; a restart skips the first four products.
//   The next beat can be taken in the cycle after the result is loaded.
//   s_ready is high only while the sequencer is idle.
//   The result sits in an output register: a stalled receiver does not block
//   acceptance of the next beat, only the hand-off of the following result.
//   Reset (aresetn low, synchronous) clears angle and rate to zero, loads the
//   register defaults (radius 1.0, all else 0) and drops m_valid.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_motion_step_unit import cms_pkg::*; #(
    parameter int CORDIC_STAGES = CMS_CORDIC_STAGES
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    // configuration write port
    input  logic                     cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [DATA_W-1:0]        cfg_wdata,
    // input channel
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_mode,
    input  logic [DT_W-1:0]          s_dt,
    // result channel
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [DATA_W-1:0] m_pos_x,
    output logic signed [DATA_W-1:0] m_pos_y,
    output logic signed [DATA_W-1:0] m_vel_x,
    output logic signed [DATA_W-1:0] m_vel_y,
    output logic [DATA_W-1:0]        m_angle_out,
    output logic signed [DATA_W-1:0] m_rate_out
);

    // Configuration registers
    logic signed [DATA_W-1:0] center_x_reg, center_y_reg;
    logic [RADIUS_W-1:0]      path_radius_reg;
    logic signed [DATA_W-1:0] omega_start_reg, ang_accel_reg;

    // Motion state
    logic [DATA_W-1:0]        angle_reg;
    logic signed [DATA_W-1:0] rate_reg;

    // Sequencer
    cms_state_t state_reg, state_next;
    logic       m_valid_reg;
    logic       accept;
    logic       out_load;

    // Working registers
    logic [DT_W-1:0]          dt_reg;
    logic [DATA_W-1:0]        dtsq_reg;
    logic signed [OFF_W-1:0]  offx_reg, offy_reg;
    logic signed [DATA_W-1:0] pv_x_reg, pv_y_reg;
    logic signed [DATA_W-1:0] vel_y_reg;

    // Output payload registers
    logic signed [DATA_W-1:0] pos_x_out_reg, pos_y_out_reg;
    logic signed [DATA_W-1:0] vel_x_out_reg, vel_y_out_reg;
    logic [DATA_W-1:0]        angle_out_reg;
    logic signed [DATA_W-1:0] rate_out_reg;

    // Shared multiplier and CORDIC hookup
    logic                     mul_en;
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] prod;
    cms_cordic_req_t          cord_req;
    cms_cordic_res_t          cord_res;

    // Values taken from the product register
    logic signed [DATA_W-1:0] rate_inc;
    logic signed [DATA_W-1:0] rate_new;
    logic signed [OFF_W-1:0]  off_new;
    logic signed [51:0]       p_full;
    logic signed [DATA_W-1:0] p_clamp;
    logic signed [38:0]       v_full;
    logic signed [DATA_W-1:0] vel_pos, vel_neg;
    logic signed [DATA_W-1:0] pos_x_new, pos_y_new;

    cms_mul u_mul (
        .aclk (aclk),
        .en   (mul_en),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    cms_cordic #(
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (cord_req),
        .res     (cord_res)
    );

    assign accept = s_valid && s_ready;

    // Product slices: rate increment, offset, clamped rate*offset, velocity
    assign rate_inc = prod[47:16];
    assign rate_new = sat32(SAT_W'(rate_reg) + SAT_W'(rate_inc));
    assign off_new  = prod[63:30];
    assign p_full   = prod[67:16];
    assign p_clamp  = (p_full > 52'sd1073741824)  ? QTR_POS :
                      (p_full < -52'sd1073741824) ? QTR_NEG : p_full[DATA_W-1:0];
    assign v_full   = prod[67:29];
    assign vel_pos  = sat32(SAT_W'(v_full));
    assign vel_neg  = sat32(-SAT_W'(v_full));

    // Position: center plus offset, saturated
    assign pos_x_new = sat32(SAT_W'(center_x_reg) + SAT_W'(offx_reg));
    assign pos_y_new = sat32(SAT_W'(center_y_reg) + SAT_W'(offy_reg));

    // Control state, motion state and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            m_valid_reg     <= 1'b0;
            angle_reg       <= '0;
            rate_reg        <= '0;
            center_x_reg    <= '0;
            center_y_reg    <= '0;
            path_radius_reg <= RADIUS_RESET;
            omega_start_reg <= '0;
            ang_accel_reg   <= '0;
        end else begin
            state_reg <= state_next;

            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            // restart, then angle increments, then rate update
            if (accept && s_mode) begin
                angle_reg <= '0;
                rate_reg  <= omega_start_reg;
            end else if (state_reg == ST_D2) begin
                angle_reg <= angle_reg + prod[31:0];
            end else if (state_reg == ST_DR) begin
                angle_reg <= angle_reg + prod[48:17];
            end else if (state_reg == ST_RATE) begin
                rate_reg <= rate_new;
            end

            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_CENTER_X:    center_x_reg    <= cfg_wdata;
                    REG_CENTER_Y:    center_y_reg    <= cfg_wdata;
                    REG_PATH_RADIUS: path_radius_reg <= cfg_wdata[RADIUS_W-1:0];
                    REG_OMEGA_START: omega_start_reg <= cfg_wdata;
                    REG_ANG_ACCEL:   ang_accel_reg   <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    // Sequencer: next state, multiplier operands, strobes
    always_comb begin
        state_next     = state_reg;
        s_ready        = 1'b0;
        mul_en         = 1'b0;
        mul_a          = '0;
        mul_b          = '0;
        cord_req.start = 1'b0;
        cord_req.angle = angle_reg;
        out_load       = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = s_mode ? ST_CSTART : ST_DTSQ;
                end
            end
            ST_DTSQ: begin
                mul_en     = 1'b1;
                mul_a      = MUL_W'(dt_reg);
                mul_b      = MUL_W'(dt_reg);
                state_next = ST_D1;
            end
            ST_D1: begin
                mul_en     = 1'b1;
                mul_a      = MUL_W'(rate_reg);
                mul_b      = MUL_W'(dt_reg);
                state_next = ST_D2;
            end
            ST_D2: begin
                mul_en     = 1'b1;
                mul_a      = MUL_W'(ang_accel_reg);
                mul_b      = MUL_W'(dtsq_reg);
                state_next = ST_DR;
            end
            ST_DR: begin
                mul_en     = 1'b1;
                mul_a      = MUL_W'(ang_accel_reg);
                mul_b      = MUL_W'(dt_reg);
                state_next = ST_RATE;
            end
            ST_RATE: begin
                state_next = ST_CSTART;
            end
            ST_CSTART: begin
                cord_req.start = 1'b1;
                state_next     = ST_CWAIT;
            end
            ST_CWAIT: begin
                if (cord_res.done) begin
                    state_next = ST_OX;
                end
            end
            ST_OX: begin
                mul_en     = 1'b1;
                mul_a      = MUL_W'(path_radius_reg);
                mul_b      = cord_res.cos_v;
                state_next = ST_OY;
            end
            ST_OY: begin
                mul_en     = 1'b1;
                mul_a      = MUL_W'(path_radius_reg);
                mul_b      = cord_res.sin_v;
                state_next = ST_PX;
            end
            ST_PX: begin
                mul_en     = 1'b1;
                mul_a      = MUL_W'(rate_reg);
                mul_b      = offx_reg;
                state_next = ST_PY;
            end
            ST_PY: begin
                mul_en     = 1'b1;
                mul_a      = MUL_W'(rate_reg);
                mul_b      = offy_reg;
                state_next = ST_VY;
            end
            ST_VY: begin
                mul_en     = 1'b1;
                mul_a      = MUL_W'(pv_x_reg);
                mul_b      = MUL_W'(TWO_PI_Q29);
                state_next = ST_VX;
            end
            ST_VX: begin
                mul_en     = 1'b1;
                mul_a      = MUL_W'(pv_y_reg);
                mul_b      = MUL_W'(TWO_PI_Q29);
                state_next = ST_DONE;
            end
            ST_DONE: begin
                // wait for the output register to be free
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Working and output payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            dt_reg <= s_dt;
        end
        case (state_reg)
            ST_D1:   dtsq_reg  <= prod[DATA_W-1:0];
            ST_OY:   offx_reg  <= off_new;
            ST_PX:   offy_reg  <= off_new;
            ST_PY:   pv_x_reg  <= p_clamp;
            ST_VY:   pv_y_reg  <= p_clamp;
            ST_VX:   vel_y_reg <= vel_pos;
            default: ;
        endcase
        if (out_load) begin
            pos_x_out_reg <= pos_x_new;
            pos_y_out_reg <= pos_y_new;
            vel_x_out_reg <= vel_neg;
            vel_y_out_reg <= vel_y_reg;
            angle_out_reg <= angle_reg;
            rate_out_reg  <= rate_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_pos_x     = pos_x_out_reg;
    assign m_pos_y     = pos_y_out_reg;
    assign m_vel_x     = vel_x_out_reg;
    assign m_vel_y     = vel_y_out_reg;
    assign m_angle_out = angle_out_reg;
    assign m_rate_out  = rate_out_reg;

    // A restart lands angle zero and the programmed start rate
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_mode) |=> (angle_reg == '0 && rate_reg == $past(omega_start_reg)))
        else $error("restart did not load angle and rate");

    // The rate only moves on a restart or in its update cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (!accept && state_reg != ST_RATE) |=> $stable(rate_reg))
        else $error("rate changed outside its update");

    // CORDIC completion is only seen while the sequencer waits for it
    assert property (@(posedge aclk) disable iff (!aresetn)
        cord_res.done |-> (state_reg == ST_CWAIT))
        else $error("CORDIC finished outside the wait state");

    // A result never appears in the cycle right after an accept
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !$rose(m_valid_reg))
        else $error("result raised too early after accept");

endmodule

`default_nettype wire
